[rtl/tcce_pkg.sv]
`default_nettype none
package tcce_pkg;

    // Screen geometry.
    localparam int COLUMNS   = 80;
    localparam int ROWS      = 25;
    localparam int TAB_WIDTH = 4;
    localparam int CELLS     = COLUMNS * ROWS;

    // Field widths.
    localparam int CELL_W = 11;
    localparam int COL_W  = 7;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;

    // Sized geometry constants.
    localparam logic [COL_W-1:0]  COLS_C     = COL_W'(COLUMNS);
    localparam logic [COL_W-1:0]  TAB_C      = COL_W'(TAB_WIDTH);
    localparam logic [CELL_W:0]   CELLS_C    = (CELL_W + 1)'(CELLS);
    localparam logic [CELL_W-1:0] LAST_ROW_C = CELL_W'(COLUMNS * (ROWS - 1));

    // Character codes with special handling.
    localparam logic [CHAR_W-1:0] CH_NULL    = 8'd0;
    localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
    localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

    // Command function codes.
    localparam logic FUNC_PLACE = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // One registered request.
    typedef struct packed {
        logic              func;
        logic [CHAR_W-1:0] char_code;
        logic [ATTR_W-1:0] attribute;
    } t_cmd;

    // One cell-write command.
    typedef struct packed {
        logic [CELL_W-1:0] start_cell;
        logic [CHAR_W-1:0] cell_char;
        logic [ATTR_W-1:0] cell_attr;
        logic [COL_W-1:0]  run_length;
        logic              scroll_up;
        logic              clear_screen_cmd;
    } t_result;

endpackage
`default_nettype wire

[rtl/text_console_cursor_engine_top.sv]
// Path: an accepted request is held in the input register, then in the result register,
// which drives the result outputs.
// Throughput: one request per cycle while the result register is not stalled; the cursor
// add and compare sits between the input register and the result register.
// Reset: synchronous, active low; clears both valid flags and puts the cursor
// at cell 0, column 0.
`default_nettype none
module text_console_cursor_engine_top (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_in_valid,
    output logic                        o_in_stall,
    input  wire                         i_func,
    input  wire  [tcce_pkg::CHAR_W-1:0] i_char_code,
    input  wire  [tcce_pkg::ATTR_W-1:0] i_attribute,
    output logic                        o_out_valid,
    input  wire                         i_out_stall,
    output logic [tcce_pkg::CELL_W-1:0] o_start_cell,
    output logic [tcce_pkg::CHAR_W-1:0] o_cell_char,
    output logic [tcce_pkg::ATTR_W-1:0] o_cell_attr,
    output logic [tcce_pkg::COL_W-1:0]  o_run_length,
    output logic                        o_scroll_up,
    output logic                        o_clear_screen_cmd
);
    import tcce_pkg::*;

    t_cmd    in_cmd;
    t_cmd    cmd;
    t_result res;
    t_result out_res;
    logic    cmd_valid;
    logic    advance;

    assign in_cmd.func      = i_func;
    assign in_cmd.char_code = i_char_code;
    assign in_cmd.attribute = i_attribute;

    // Input register.
    tcce_in_reg u_in (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_in_valid),
        .o_stall   (o_in_stall),
        .i_cmd     (in_cmd),
        .i_advance (advance),
        .o_valid   (cmd_valid),
        .o_cmd     (cmd)
    );

    // Cursor tracking and command build.
    tcce_cursor u_cursor (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_update (cmd_valid && advance),
        .i_cmd    (cmd),
        .o_res    (res)
    );

    // Result register.
    tcce_out_reg u_out (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (cmd_valid),
        .i_res     (res),
        .i_stall   (i_out_stall),
        .o_advance (advance),
        .o_valid   (o_out_valid),
        .o_res     (out_res)
    );

    assign o_start_cell       = out_res.start_cell;
    assign o_cell_char        = out_res.cell_char;
    assign o_cell_attr        = out_res.cell_attr;
    assign o_run_length       = out_res.run_length;
    assign o_scroll_up        = out_res.scroll_up;
    assign o_clear_screen_cmd = out_res.clear_screen_cmd;

endmodule
`default_nettype wire

[rtl/tcce_in_reg.sv]
`default_nettype none
module tcce_in_reg (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_valid,
    output logic                  o_stall,
    input  wire  tcce_pkg::t_cmd  i_cmd,
    input  wire                   i_advance,
    output logic                  o_valid,
    output tcce_pkg::t_cmd        o_cmd
);
    import tcce_pkg::*;

    logic r_valid;
    t_cmd r_cmd;

    // The register may load when it is empty or when its request moves on.
    assign o_stall = r_valid && !i_advance;
    assign o_valid = r_valid;
    assign o_cmd   = r_cmd;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (!o_stall) begin
            r_valid <= i_valid;
        end
    end

    // Request payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_cmd <= i_cmd;
        end
    end

endmodule
`default_nettype wire

[rtl/tcce_cursor.sv]
`default_nettype none
module tcce_cursor (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   i_update,
    input  wire  tcce_pkg::t_cmd  i_cmd,
    output tcce_pkg::t_result     o_res
);
    import tcce_pkg::*;

    logic [CELL_W-1:0] r_cell;
    logic [COL_W-1:0]  r_col;
    logic [CELL_W-1:0] n_cell;
    logic [COL_W-1:0]  n_col;
    logic [COL_W-1:0]  rem;
    logic [COL_W-1:0]  run;
    logic [CHAR_W-1:0] wchar;
    logic [CELL_W:0]   cell_sum;
    logic [COL_W:0]    col_sum;

    // Run length and written character for a place request.
    always_comb begin
        rem = COLS_C - r_col;
        if (i_cmd.char_code == CH_NULL) begin
            run   = '0;
            wchar = CH_NULL;
        end else if (i_cmd.char_code == CH_NEWLINE) begin
            run   = rem;
            wchar = CH_SPACE;
        end else if (i_cmd.char_code == CH_TAB) begin
            run   = (TAB_C < rem) ? TAB_C : rem;
            wchar = CH_SPACE;
        end else begin
            run   = COL_W'(1);
            wchar = i_cmd.char_code;
        end
    end

    // Cursor advance with row wrap and scroll at the screen end; a clear homes the cursor.
    always_comb begin
        cell_sum = {1'b0, r_cell} + (CELL_W + 1)'(run);
        col_sum  = {1'b0, r_col} + {1'b0, run};
        n_cell   = cell_sum[CELL_W-1:0];
        n_col    = (col_sum >= {1'b0, COLS_C}) ? '0 : col_sum[COL_W-1:0];
        o_res.start_cell       = r_cell;
        o_res.cell_char        = wchar;
        o_res.cell_attr        = i_cmd.attribute;
        o_res.run_length       = run;
        o_res.scroll_up        = 1'b0;
        o_res.clear_screen_cmd = 1'b0;
        if (cell_sum >= CELLS_C) begin
            n_cell          = LAST_ROW_C;
            n_col           = '0;
            o_res.scroll_up = 1'b1;
        end
        if (i_cmd.func == FUNC_CLEAR) begin
            n_cell = '0;
            n_col  = '0;
            o_res  = '0;
            o_res.clear_screen_cmd = 1'b1;
        end
    end

    // Cursor state moves once per request that leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell <= '0;
            r_col  <= '0;
        end else if (i_update) begin
            r_cell <= n_cell;
            r_col  <= n_col;
        end
    end

endmodule
`default_nettype wire

[rtl/tcce_out_reg.sv]
`default_nettype none
module tcce_out_reg (
    input  wire                      i_clk,
    input  wire                      i_rst_n,
    input  wire                      i_valid,
    input  wire  tcce_pkg::t_result  i_res,
    input  wire                      i_stall,
    output logic                     o_advance,
    output logic                     o_valid,
    output tcce_pkg::t_result        o_res
);
    import tcce_pkg::*;

    logic    r_valid;
    t_result r_res;

    // A new result may load when the register is empty or being taken.
    assign o_advance = !r_valid || !i_stall;
    assign o_valid   = r_valid;
    assign o_res     = r_res;

    // Valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_advance) begin
            r_valid <= i_valid;
        end
    end

    // Result payload.
    always_ff @(posedge i_clk) begin
        if (i_valid && o_advance) begin
            r_res <= i_res;
        end
    end

endmodule
`default_nettype wire

[rtl/tcce_checker.sv]
`default_nettype none
module tcce_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_in_valid,
    input wire                         o_in_stall,
    input wire                         o_out_valid,
    input wire                         i_out_stall,
    input wire [tcce_pkg::CELL_W-1:0]  o_start_cell,
    input wire [tcce_pkg::COL_W-1:0]   o_run_length,
    input wire                         o_scroll_up,
    input wire                         o_clear_screen_cmd
);
    import tcce_pkg::*;

    // A clear command carries no cell write and no scroll.
    a_clear_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_clear_screen_cmd |->
            o_start_cell == '0 && o_run_length == '0 && !o_scroll_up)
        else $error("clear command carries write fields");

    // A write never starts beyond the screen and never runs longer than a row.
    a_write_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> {1'b0, o_start_cell} < CELLS_C && o_run_length <= COLS_C)
        else $error("cell write out of range");

    // A scroll is only asked for by a write that starts on the bottom row.
    a_scroll_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_scroll_up |-> o_start_cell >= LAST_ROW_C)
        else $error("scroll from a write above the bottom row");

    // Input is held off only while the result register is stalled.
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid && i_out_stall)
        else $error("input stalled without a stalled result");

    // A stalled result holds.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_start_cell))
        else $error("stalled result changed");

endmodule

bind text_console_cursor_engine_top tcce_checker u_tcce_checker (.*);
`default_nettype wire

[bench/text_console_cursor_engine_top_tb.sv]
`timescale 1ns / 1ps
module text_console_cursor_engine_top_tb;
    import tcce_pkg::*;

    localparam int IDLE_LIMIT = 2000;
    localparam int MAX_REPORTS = 100;

    typedef enum int {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } t_stall_mode;

    logic              i_clk       = 1'b0;
    logic              i_rst_n     = 1'b0;
    logic              i_in_valid  = 1'b0;
    logic              i_func      = FUNC_PLACE;
    logic [CHAR_W-1:0] i_char_code = '0;
    logic [ATTR_W-1:0] i_attribute = '0;
    logic              i_out_stall = 1'b0;
    logic              o_in_stall;
    logic              o_out_valid;
    logic [CELL_W-1:0] o_start_cell;
    logic [CHAR_W-1:0] o_cell_char;
    logic [ATTR_W-1:0] o_cell_attr;
    logic [COL_W-1:0]  o_run_length;
    logic              o_scroll_up;
    logic              o_clear_screen_cmd;

    // Predicted cursor position, kept in step with accepted requests.
    int cursor_cell_q = 0;
    int cursor_col_q = 0;

    t_result     pending_writes[$];
    int          mismatch_count = 0;
    int          burst_left = 1;
    int          idle_cycles = 0;
    int          stall_phase_left = 0;
    int          stall_tick = 0;
    t_stall_mode stall_mode = STALL_NONE;

    text_console_cursor_engine_top dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_stall         (o_in_stall),
        .i_func             (i_func),
        .i_char_code        (i_char_code),
        .i_attribute        (i_attribute),
        .o_out_valid        (o_out_valid),
        .i_out_stall        (i_out_stall),
        .o_start_cell       (o_start_cell),
        .o_cell_char        (o_cell_char),
        .o_cell_attr        (o_cell_attr),
        .o_run_length       (o_run_length),
        .o_scroll_up        (o_scroll_up),
        .o_clear_screen_cmd (o_clear_screen_cmd)
    );

    always #5 i_clk = ~i_clk;

    // Work out the cell write for one request and move the predicted cursor.
    function automatic t_result predict_cell_write(input logic func,
                                                   input logic [CHAR_W-1:0] ch,
                                                   input logic [ATTR_W-1:0] attr);
        t_result wr;
        int      cells_left;
        int      run;
        wr = '0;
        if (func == FUNC_CLEAR) begin
            wr.clear_screen_cmd = 1'b1;
            cursor_cell_q = 0;
            cursor_col_q = 0;
            return wr;
        end
        wr.start_cell = CELL_W'(cursor_cell_q);
        wr.cell_attr = attr;
        cells_left = COLUMNS - cursor_col_q;
        case (ch)
            CH_NULL: begin
                run = 0;
                wr.cell_char = CH_NULL;
            end
            CH_NEWLINE: begin
                run = cells_left;
                wr.cell_char = CH_SPACE;
            end
            CH_TAB: begin
                run = (TAB_WIDTH < cells_left) ? TAB_WIDTH : cells_left;
                wr.cell_char = CH_SPACE;
            end
            default: begin
                run = 1;
                wr.cell_char = ch;
            end
        endcase
        wr.run_length = COL_W'(run);
        cursor_cell_q += run;
        cursor_col_q += run;
        if (cursor_col_q >= COLUMNS) begin
            cursor_col_q = 0;
        end
        // Moving past the last cell scrolls and parks the cursor on the bottom row.
        if (cursor_cell_q >= CELLS) begin
            cursor_cell_q = COLUMNS * (ROWS - 1);
            cursor_col_q = 0;
            wr.scroll_up = 1'b1;
        end
        return wr;
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        if (mismatch_count < MAX_REPORTS) begin
            $display("%0t: mismatch on %s: got %0d, expected %0d", $realtime, what, got, want);
        end
        mismatch_count++;
    endtask

    // Record the expected write for every accepted request.
    always @(posedge i_clk) begin
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            pending_writes.push_back(predict_cell_write(i_func, i_char_code, i_attribute));
        end
    end

    // Compare every accepted cell write with the oldest prediction.
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_writes.size() == 0) begin
                report_mismatch("unrequested write", o_start_cell, -1);
            end else begin
                want = pending_writes.pop_front();
                if (o_start_cell !== want.start_cell)
                    report_mismatch("start_cell", o_start_cell, want.start_cell);
                if (o_cell_char !== want.cell_char)
                    report_mismatch("cell_char", o_cell_char, want.cell_char);
                if (o_cell_attr !== want.cell_attr)
                    report_mismatch("cell_attr", o_cell_attr, want.cell_attr);
                if (o_run_length !== want.run_length)
                    report_mismatch("run_length", o_run_length, want.run_length);
                if (o_scroll_up !== want.scroll_up)
                    report_mismatch("scroll_up", o_scroll_up, want.scroll_up);
                if (o_clear_screen_cmd !== want.clear_screen_cmd)
                    report_mismatch("clear_screen_cmd", o_clear_screen_cmd,
                                    want.clear_screen_cmd);
            end
        end
    end

    // The output side switches at random between stall patterns.
    always @(posedge i_clk) begin
        stall_tick <= stall_tick + 1;
        if (stall_phase_left == 0) begin
            stall_mode <= t_stall_mode'($urandom_range(0, 3));
            stall_phase_left <= $urandom_range(20, 80);
        end else begin
            stall_phase_left <= stall_phase_left - 1;
        end
        case (stall_mode)
            STALL_NONE:     i_out_stall <= 1'b0;
            STALL_LIGHT:    i_out_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY:    i_out_stall <= ($urandom_range(0, 3) != 0);
            STALL_PERIODIC: i_out_stall <= stall_tick[2];
            default:        i_out_stall <= 1'b0;
        endcase
    end

    // Stop the run when neither side has moved for too long.
    always @(posedge i_clk) begin
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
        if (idle_cycles >= IDLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Present one request, hold it until accepted, then maybe leave a gap.
    task automatic send_request(input logic func, input logic [CHAR_W-1:0] ch,
                                input logic [ATTR_W-1:0] attr);
        int gap;
        i_in_valid <= 1'b1;
        i_func <= func;
        i_char_code <= ch;
        i_attribute <= attr;
        @(posedge i_clk);
        while (o_in_stall) begin
            @(posedge i_clk);
        end
        burst_left--;
        if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
    endtask

    // Hold off new requests until every predicted write has come back.
    task automatic wait_for_drain();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_writes.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    // Random text with the given percentages of newlines, tabs, null bytes
    // and clears; everything else is a nonzero byte other than tab or newline.
    task automatic send_text_stream(input int count, input int pct_newline,
                                    input int pct_tab, input int pct_null,
                                    input int pct_clear);
        int                roll;
        logic              func;
        logic [CHAR_W-1:0] ch;
        for (int n = 0; n < count; n++) begin
            roll = $urandom_range(0, 99);
            func = FUNC_PLACE;
            ch = CHAR_W'($urandom_range(1, 255));
            if (ch == CH_TAB || ch == CH_NEWLINE) begin
                ch = ch ^ 8'h80;
            end
            if (roll < pct_clear) begin
                func = FUNC_CLEAR;
                ch = CHAR_W'($urandom_range(0, 255));
            end else if (roll < pct_clear + pct_null) begin
                ch = CH_NULL;
            end else if (roll < pct_clear + pct_null + pct_newline) begin
                ch = CH_NEWLINE;
            end else if (roll < pct_clear + pct_null + pct_newline + pct_tab) begin
                ch = CH_TAB;
            end
            send_request(func, ch, ATTR_W'($urandom_range(0, 255)));
        end
    endtask

    // Field extremes, each character class, clear with junk fields, and
    // a newline from the first column.
    task automatic test_field_extremes();
        send_request(FUNC_CLEAR, 8'hFF, 8'hFF);
        send_request(FUNC_PLACE, 8'hFF, 8'hFF);
        send_request(FUNC_PLACE, 8'h01, 8'h00);
        send_request(FUNC_PLACE, CH_NULL, 8'hA5);
        send_request(FUNC_PLACE, CH_TAB, 8'h0F);
        send_request(FUNC_PLACE, CH_NEWLINE, 8'h70);
        send_request(FUNC_PLACE, CH_NEWLINE, 8'h80);
        send_request(FUNC_PLACE, CH_SPACE, 8'h00);
        send_request(FUNC_PLACE, 8'h80, 8'h7F);
        send_request(FUNC_CLEAR, CH_NULL, 8'h00);
        send_request(FUNC_PLACE, CH_TAB, 8'hFF);
        send_request(FUNC_PLACE, CH_NULL, 8'h00);
        wait_for_drain();
    endtask

    // Mixed text that wanders over the whole screen.
    task automatic test_mixed_text();
        send_text_stream(250, 10, 15, 5, 2);
        wait_for_drain();
    endtask

    // Tab-heavy rows, so tabs regularly get clipped at the row end.
    task automatic test_tab_clipping();
        send_text_stream(120, 3, 45, 3, 1);
        wait_for_drain();
    endtask

    // Newline-heavy text that keeps hitting the bottom of the screen.
    task automatic test_scrolling();
        send_text_stream(130, 40, 15, 3, 0);
        wait_for_drain();
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_field_extremes();
        test_mixed_text();
        test_tab_clipping();
        test_scrolling();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0 && pending_writes.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
